// ----- rtl/fmop_pkg.sv -----
// ----------------------------------------------------------------------------
// fmop_pkg
// Shared types, codes and fixed-point helpers for the FM operator with its
// exponential ADSR envelope.
// ----------------------------------------------------------------------------
package fmop_pkg;

    // Sine lookup resolution and phase accumulator width.
    localparam int SINE_TABLE_BITS = 10;
    localparam int PHASE_BITS      = 32;

    // Alignment of the accumulator to a 32-bit turn.
    localparam int PH_DN = (PHASE_BITS > 32) ? (PHASE_BITS - 32) : 0;
    localparam int PH_UP = (PHASE_BITS < 32) ? (32 - PHASE_BITS) : 0;

    // Quarter-wave position: index bits below the quadrant, placed in Q0.30.
    localparam int QW_BITS  = SINE_TABLE_BITS - 2;
    localparam int QW_SHIFT = 30 - QW_BITS;

    // Request opcodes carried in tuser.
    localparam logic [1:0] OP_SAMPLE   = 2'd0;
    localparam logic [1:0] OP_NOTE_ON  = 2'd1;
    localparam logic [1:0] OP_NOTE_OFF = 2'd2;
    localparam logic [1:0] OP_RESET    = 2'd3;

    // Configuration register map, one 32-bit word per register.
    localparam int CFG_ADDR_W = 5;
    localparam logic [2:0] REG_ATTACK     = 3'd0;
    localparam logic [2:0] REG_DECAY      = 3'd1;
    localparam logic [2:0] REG_RELEASE    = 3'd2;
    localparam logic [2:0] REG_SUSTAIN    = 3'd3;
    localparam logic [2:0] REG_IDX_SUS    = 3'd4;
    localparam logic [2:0] REG_IDX_DECAY  = 3'd5;
    localparam logic [2:0] REG_FEEDBACK   = 3'd6;
    localparam logic [2:0] REG_LEVEL      = 3'd7;

    // Envelope full scale in Q1.16.
    localparam logic [16:0] FULL_ENV = 17'd65536;

    // Odd polynomial coefficients for sin(pi/2 x), unsigned Q30.
    localparam logic [31:0] SIN_A1 = 32'd1686629713;
    localparam logic [31:0] SIN_A3 = 32'd693598670;
    localparam logic [31:0] SIN_A5 = 32'd85569306;
    localparam logic [31:0] SIN_A7 = 32'd5026995;
    localparam logic [31:0] SIN_A9 = 32'd172272;

    // Horner coefficients in the order they are consumed.
    localparam logic [31:0] SIN_COEF [4] = '{SIN_A7, SIN_A5, SIN_A3, SIN_A1};

    typedef logic [PHASE_BITS-1:0] t_phase;

    // Configuration register contents.
    typedef struct packed {
        logic [15:0] attack_coeff;
        logic [15:0] decay_coeff;
        logic [15:0] release_coeff;
        logic [16:0] sustain_level;
        logic [15:0] index_sustain;
        logic [15:0] index_decay_coeff;
        logic [15:0] feedback_gain;
        logic [16:0] output_level;
    } t_cfg;

    // Accumulator value expressed in 2^-32 turn units.
    function automatic logic [31:0] phase_to32(input t_phase p);
        logic [63:0] w;
        w = 64'(p);
        return 32'((w >> PH_DN) << PH_UP);
    endfunction

    // Phase step aligned to the accumulator width.
    function automatic t_phase step_align(input logic [31:0] s);
        logic [63:0] w;
        w = 64'(s);
        return PHASE_BITS'((w << PH_DN) >> PH_UP);
    endfunction

endpackage

// ----- rtl/fm_operator_with_envelope_unit.sv -----
// ----------------------------------------------------------------------------
// fm_operator_with_envelope_unit
// Phase-modulation sine operator with exponential ADSR envelope, built around
// one registered 32x32 multiplier driven by a small sequencer.
// A sample request runs through the sequencer and makes 12 passes through the
// shared multiplier; a control request goes straight to the output state.
// A new request is taken only once the previous result has moved into the
// output register, so a stalled result side also holds off requests.
// Reset: synchronous, clears the voice state, the output register and the
// registers to their defaults.
// ----------------------------------------------------------------------------
module fm_operator_with_envelope_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Request stream.
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [63:0]                   i_s_axis_tdata,  // mod_input, phase_step, start_index
    input  logic [1:0]                    i_s_axis_tuser,  // opcode
    // Result stream.
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [15:0]                   o_m_axis_tdata,  // sample
    output logic [0:0]                    o_m_axis_tuser,  // active
    // Register port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fmop_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import fmop_pkg::*;

    // Sequencer states.
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_IDX  = 5'd1;
    localparam logic [4:0] S_FB   = 5'd2;
    localparam logic [4:0] S_MIX  = 5'd3;
    localparam logic [4:0] S_OFF  = 5'd4;
    localparam logic [4:0] S_PH   = 5'd5;
    localparam logic [4:0] S_SQ   = 5'd6;
    localparam logic [4:0] S_X2   = 5'd7;
    localparam logic [4:0] S_HM   = 5'd8;
    localparam logic [4:0] S_HS   = 5'd9;
    localparam logic [4:0] S_Y    = 5'd10;
    localparam logic [4:0] S_ENV  = 5'd11;
    localparam logic [4:0] S_ENVU = 5'd12;
    localparam logic [4:0] S_O1   = 5'd13;
    localparam logic [4:0] S_O2   = 5'd14;
    localparam logic [4:0] S_SAT  = 5'd15;
    localparam logic [4:0] S_FIN  = 5'd16;

    // Envelope stages.
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_ATTACK  = 3'd1;
    localparam logic [2:0] ST_DECAY   = 3'd2;
    localparam logic [2:0] ST_SUSTAIN = 3'd3;
    localparam logic [2:0] ST_RELEASE = 3'd4;

    localparam logic [30:0] X_ONE      = 31'h4000_0000;
    localparam logic [17:0] DECAY_SNAP = 18'd7;

    t_cfg cfg;

    // Control and voice state.
    logic [4:0]         r_state;
    logic [1:0]         r_k;
    t_phase             r_phase;
    logic [31:0]        r_step;
    logic [15:0]        r_live;
    logic signed [15:0] r_prior;
    logic [16:0]        r_env;
    logic [2:0]         r_stage;
    logic               r_ov;

    // Working registers of the current sample.
    logic [63:0]        r_prod;
    logic [15:0]        r_mod;
    logic [15:0]        r_mag;
    logic               r_mneg;
    logic [31:0]        r_p;
    logic [30:0]        r_x;
    logic [31:0]        r_x2;
    logic [31:0]        r_h;
    logic [14:0]        r_y;
    logic               r_sneg;
    logic [15:0]        r_res;
    logic [15:0]        r_odata;
    logic               r_oact;

    // Combinational helpers.
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [16:0]        sus_eff;
    logic               live_ge;
    logic [15:0]        idx_dmag;
    logic [15:0]        live_new;
    logic               prior_neg;
    logic [15:0]        prior_mag;
    logic signed [17:0] mix_fb;
    logic signed [17:0] mix_sum;
    logic [17:0]        mix_abs;
    logic [31:0]        off;
    logic [31:0]        ph_mod;
    logic [SINE_TABLE_BITS-1:0] sn_idx;
    logic [1:0]         sn_quad;
    logic [30:0]        sn_r;
    logic [30:0]        sn_x;
    logic [18:0]        y_raw;
    logic [14:0]        y_cap;
    logic               env_gt;
    logic [16:0]        env_dec_b;
    logic [16:0]        env_term;
    logic [16:0]        at_env;
    logic [16:0]        dc_env;
    logic [31:0]        out_mag;
    logic [15:0]        out_sat;

    fmop_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign o_s_axis_tready   = (r_state == S_IDLE);
    assign o_m_axis_tvalid   = r_ov;
    assign o_m_axis_tdata    = r_odata;
    assign o_m_axis_tuser[0] = r_oact;

    // Sustain above full scale acts as full scale.
    assign sus_eff = (cfg.sustain_level > FULL_ENV) ? FULL_ENV : cfg.sustain_level;

    // Index smoothing toward the settled value.
    assign live_ge  = (r_live >= cfg.index_sustain);
    assign idx_dmag = live_ge ? (r_live - cfg.index_sustain) : (cfg.index_sustain - r_live);
    assign live_new = live_ge ? (cfg.index_sustain + r_prod[31:16])
                              : (cfg.index_sustain - r_prod[31:16]);

    // Feedback from the previous output, truncated toward zero.
    assign prior_neg = r_prior[15];
    assign prior_mag = prior_neg ? 16'(-r_prior) : 16'(r_prior);
    assign mix_fb    = prior_neg ? (18'sd0 - $signed({2'b00, r_prod[31:16]}))
                                 : $signed({2'b00, r_prod[31:16]});
    assign mix_sum   = $signed({{2{r_mod[15]}}, r_mod}) + mix_fb;
    assign mix_abs   = mix_sum[17] ? 18'(-mix_sum) : 18'(mix_sum);

    // Modulated phase: offset in 2^-32 turns, wrapping within one turn.
    assign off    = {r_prod[26:0], 5'b00000};
    assign ph_mod = phase_to32(r_phase) + (r_mneg ? (32'd0 - off) : off);

    // Quadrant and mirrored quarter-wave position.
    assign sn_idx  = r_p[31 -: SINE_TABLE_BITS];
    assign sn_quad = sn_idx[SINE_TABLE_BITS-1 -: 2];
    assign sn_r    = 31'(sn_idx[QW_BITS-1:0]) << QW_SHIFT;
    assign sn_x    = sn_quad[0] ? (X_ONE - sn_r) : sn_r;

    // Sine magnitude in Q15, capped just below one.
    assign y_raw = r_prod[63:45];
    assign y_cap = (y_raw > 19'd32767) ? 15'h7FFF : y_raw[14:0];

    // Envelope terms.
    assign env_gt    = (r_env > sus_eff);
    assign env_dec_b = env_gt ? (r_env - sus_eff) : 17'd0;
    assign env_term  = r_prod[32:16];
    assign at_env    = FULL_ENV - env_term;
    assign dc_env    = env_gt ? (sus_eff + env_term) : r_env;

    // Scaled output with the sign restored and saturated.
    assign out_mag = r_prod[47:16];
    always_comb begin
        if (r_sneg) begin
            out_sat = (out_mag > 32'd32768) ? 16'h8000 : 16'(16'd0 - out_mag[15:0]);
        end else begin
            out_sat = (out_mag > 32'd32767) ? 16'h7FFF : out_mag[15:0];
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_IDX: begin
                mul_a = 32'(cfg.index_decay_coeff);
                mul_b = 32'(idx_dmag);
            end
            S_FB: begin
                mul_a = 32'(cfg.feedback_gain);
                mul_b = 32'(prior_mag);
            end
            S_OFF: begin
                mul_a = 32'(r_mag);
                mul_b = 32'(r_live);
            end
            S_SQ: begin
                mul_a = 32'(sn_x);
                mul_b = 32'(sn_x);
            end
            S_HM: begin
                mul_a = r_x2;
                mul_b = r_h;
            end
            S_Y: begin
                mul_a = 32'(r_x);
                mul_b = r_h;
            end
            S_ENV: begin
                case (r_stage)
                    ST_ATTACK: begin
                        mul_a = 32'(cfg.attack_coeff);
                        mul_b = 32'(FULL_ENV - r_env);
                    end
                    ST_DECAY: begin
                        mul_a = 32'(cfg.decay_coeff);
                        mul_b = 32'(env_dec_b);
                    end
                    ST_RELEASE: begin
                        mul_a = 32'(cfg.release_coeff);
                        mul_b = 32'(r_env);
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            S_O1: begin
                mul_a = 32'(r_y);
                mul_b = 32'(r_env);
            end
            S_O2: begin
                mul_a = out_mag;
                mul_b = 32'(cfg.output_level);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Shared multiplier; each product is consumed in the following state.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Sequencer and voice state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_phase <= '0;
            r_step  <= '0;
            r_live  <= '0;
            r_prior <= '0;
            r_env   <= '0;
            r_stage <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            // The output register empties unless a new result replaces it.
            if (r_ov && i_m_axis_tready && (r_state != S_FIN)) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_mod <= i_s_axis_tdata[15:0];
                        r_res <= '0;
                        unique case (i_s_axis_tuser)
                            OP_SAMPLE: begin
                                r_state <= S_IDX;
                            end
                            OP_NOTE_ON: begin
                                r_step  <= i_s_axis_tdata[47:16];
                                r_live  <= i_s_axis_tdata[63:48];
                                r_prior <= '0;
                                r_stage <= ST_ATTACK;
                                r_state <= S_FIN;
                            end
                            OP_NOTE_OFF: begin
                                if (r_stage != ST_IDLE) begin
                                    r_stage <= ST_RELEASE;
                                end
                                r_state <= S_FIN;
                            end
                            OP_RESET: begin
                                r_phase <= '0;
                                r_prior <= '0;
                                r_live  <= cfg.index_sustain;
                                r_env   <= '0;
                                r_stage <= ST_IDLE;
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_IDX: begin
                    r_state <= S_FB;
                end
                S_FB: begin
                    r_live  <= live_new;
                    r_state <= S_MIX;
                end
                S_MIX: begin
                    r_mag   <= mix_abs[15:0];
                    r_mneg  <= mix_sum[17];
                    r_state <= S_OFF;
                end
                S_OFF: begin
                    r_state <= S_PH;
                end
                S_PH: begin
                    r_p     <= ph_mod;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_x     <= sn_x;
                    r_sneg  <= sn_quad[1];
                    r_h     <= SIN_A9;
                    r_k     <= '0;
                    r_state <= S_X2;
                end
                S_X2: begin
                    r_x2    <= r_prod[61:30];
                    r_state <= S_HM;
                end
                S_HM: begin
                    r_state <= S_HS;
                end
                // One Horner step: h = a_k - x2*h.
                S_HS: begin
                    r_h <= SIN_COEF[r_k] - r_prod[61:30];
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_state <= S_Y;
                    end else begin
                        r_state <= S_HM;
                    end
                end
                S_Y: begin
                    r_state <= S_ENV;
                end
                S_ENV: begin
                    r_y     <= y_cap;
                    r_state <= S_ENVU;
                end
                // Envelope update for this sample.
                S_ENVU: begin
                    case (r_stage)
                        ST_ATTACK: begin
                            if (at_env >= FULL_ENV) begin
                                r_env   <= FULL_ENV;
                                r_stage <= ST_DECAY;
                            end else begin
                                r_env <= at_env;
                            end
                        end
                        ST_DECAY: begin
                            if ({1'b0, dc_env} <= ({1'b0, sus_eff} + DECAY_SNAP)) begin
                                r_env   <= sus_eff;
                                r_stage <= ST_SUSTAIN;
                            end else begin
                                r_env <= dc_env;
                            end
                        end
                        ST_SUSTAIN: begin
                            r_env <= sus_eff;
                        end
                        ST_RELEASE: begin
                            r_env <= env_term;
                            if (env_term == 17'd0) begin
                                r_stage <= ST_IDLE;
                            end
                        end
                        default: begin
                            r_env   <= '0;
                            r_stage <= ST_IDLE;
                        end
                    endcase
                    r_state <= S_O1;
                end
                S_O1: begin
                    r_state <= S_O2;
                end
                S_O2: begin
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    r_res   <= out_sat;
                    r_prior <= out_sat;
                    r_phase <= r_phase + step_align(r_step);
                    r_state <= S_FIN;
                end
                // Hand the result to the output register once it is free.
                S_FIN: begin
                    if (!r_ov || i_m_axis_tready) begin
                        r_ov    <= 1'b1;
                        r_odata <= r_res;
                        r_oact  <= (r_stage != ST_IDLE);
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/fmop_cfg.sv -----
// ----------------------------------------------------------------------------
// fmop_cfg
// APB register file holding the envelope, index and gain settings.
// ----------------------------------------------------------------------------
module fmop_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fmop_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output fmop_pkg::t_cfg                o_cfg
);
    import fmop_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[CFG_ADDR_W-1:2];
    assign o_cfg   = r_cfg;

    // Register writes on the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_coeff      <= '0;
            r_cfg.decay_coeff       <= '0;
            r_cfg.release_coeff     <= '0;
            r_cfg.sustain_level     <= FULL_ENV;
            r_cfg.index_sustain     <= '0;
            r_cfg.index_decay_coeff <= '0;
            r_cfg.feedback_gain     <= '0;
            r_cfg.output_level      <= FULL_ENV;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_ATTACK:    r_cfg.attack_coeff      <= pwdata[15:0];
                REG_DECAY:     r_cfg.decay_coeff       <= pwdata[15:0];
                REG_RELEASE:   r_cfg.release_coeff     <= pwdata[15:0];
                REG_SUSTAIN:   r_cfg.sustain_level     <= pwdata[16:0];
                REG_IDX_SUS:   r_cfg.index_sustain     <= pwdata[15:0];
                REG_IDX_DECAY: r_cfg.index_decay_coeff <= pwdata[15:0];
                REG_FEEDBACK:  r_cfg.feedback_gain     <= pwdata[15:0];
                REG_LEVEL:     r_cfg.output_level      <= pwdata[16:0];
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        unique case (reg_sel)
            REG_ATTACK:    prdata = 32'(r_cfg.attack_coeff);
            REG_DECAY:     prdata = 32'(r_cfg.decay_coeff);
            REG_RELEASE:   prdata = 32'(r_cfg.release_coeff);
            REG_SUSTAIN:   prdata = 32'(r_cfg.sustain_level);
            REG_IDX_SUS:   prdata = 32'(r_cfg.index_sustain);
            REG_IDX_DECAY: prdata = 32'(r_cfg.index_decay_coeff);
            REG_FEEDBACK:  prdata = 32'(r_cfg.feedback_gain);
            REG_LEVEL:     prdata = 32'(r_cfg.output_level);
        endcase
    end

endmodule

// ----- rtl/fmop_chk.sv -----
// ----------------------------------------------------------------------------
// fmop_chk
// Port-level checks for the FM operator, bound to the top level.
// ----------------------------------------------------------------------------
module fmop_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    input  logic                          o_s_axis_tready,
    input  logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    input  logic [15:0]                   o_m_axis_tdata,
    input  logic [0:0]                    o_m_axis_tuser
);

    // The sequencer takes one request at a time.
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("request accepted while the previous one was still in work");

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed or vanished");

    // With the envelope idle after the request, the sample must be silent.
    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tdata == 16'd0))
        else $error("nonzero sample reported with an idle envelope");

    // Reset empties the output register and leaves the block ready.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_axis_tvalid && o_s_axis_tready))
        else $error("block not idle after reset");

endmodule

bind fm_operator_with_envelope_unit fmop_chk u_fmop_chk (.*);

// ----- sim/fm_operator_with_envelope_unit_checker.sv -----
// ----------------------------------------------------------------------------
// fmop_checker
// Watches the request, result and register channels of the FM operator.
// It keeps its own copy of the voice state and the registers, predicts the
// result of every accepted request, and compares results in order.
// ----------------------------------------------------------------------------
module fmop_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Request channel as seen at the block's input.
    input  logic                            i_req_valid,
    input  logic                            i_req_ready,
    input  logic [63:0]                     i_req_data,   // mod_input, phase_step, start_index
    input  logic [1:0]                      i_req_user,   // opcode
    // Result channel as seen at the block's output.
    input  logic                            i_rsp_valid,
    input  logic                            i_rsp_ready,
    input  logic [15:0]                     i_rsp_data,   // sample
    input  logic [0:0]                      i_rsp_user,   // active
    // Register port.
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic                            i_pready,
    input  logic [fmop_pkg::CFG_ADDR_W-1:0] i_paddr,
    input  logic [31:0]                     i_pwdata,
    output int                              o_failures,
    output int                              o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import fmop_pkg::*;

    localparam int TABLE_BITS = SINE_TABLE_BITS;

    // Odd terms of the quarter-wave sine polynomial, unsigned Q30.
    localparam logic [63:0] SIN_C1 = 64'd1686629713;
    localparam logic [63:0] SIN_C3 = 64'd693598670;
    localparam logic [63:0] SIN_C5 = 64'd85569306;
    localparam logic [63:0] SIN_C7 = 64'd5026995;
    localparam logic [63:0] SIN_C9 = 64'd172272;

    localparam logic [63:0] ENV_FULL   = 64'd65536;
    localparam logic [63:0] DECAY_SNAP = 64'd7;

    typedef enum logic [2:0] {
        ENV_IDLE    = 3'd0,
        ENV_ATTACK  = 3'd1,
        ENV_DECAY   = 3'd2,
        ENV_SUSTAIN = 3'd3,
        ENV_RELEASE = 3'd4
    } env_stage_e;

    typedef struct packed {
        logic [15:0] sample;
        logic        active;
    } operator_result_t;

    // Register copies.
    logic [15:0] attack_c, decay_c, release_c;
    logic [16:0] sustain_lvl;
    logic [15:0] idx_sus, idx_decay, fb_gain;
    logic [16:0] out_level;

    // Voice state.
    logic [31:0]        phase_acc;
    logic [31:0]        step_size;
    logic [15:0]        live_index;
    logic signed [15:0] prior_output;
    logic [16:0]        env_value;
    env_stage_e         env_stage;

    operator_result_t due_results[$];
    operator_result_t want;

    // Advances the voice by one request and returns the result it yields.
    function automatic operator_result_t operator_step(input logic [1:0] op,
                                                       input logic [63:0] fields);
        operator_result_t   res;
        logic signed [15:0] mod_in;
        int                 prior, fb, m, s;
        logic [63:0]        fb_mag, off, r, x, x2, h, y, env, scaled;
        logic [31:0]        gap, sus, ph;
        logic [TABLE_BITS-1:0] slot;
        logic [1:0]         quad;
        res.sample = '0;
        case (op)
            OP_SAMPLE: begin
                mod_in = fields[15:0];
                // Glide the modulation index toward its settled value.
                if (live_index >= idx_sus) begin
                    gap = 32'(live_index) - 32'(idx_sus);
                    live_index = idx_sus + 16'((64'(idx_decay) * 64'(gap)) >> 16);
                end else begin
                    gap = 32'(idx_sus) - 32'(live_index);
                    live_index = idx_sus - 16'((64'(idx_decay) * 64'(gap)) >> 16);
                end

                // Self-feedback, truncated toward zero, added to the modulator.
                prior = int'(prior_output);
                fb_mag = (64'(fb_gain) * 64'(prior < 0 ? -prior : prior)) >> 16;
                fb = prior < 0 ? -int'(fb_mag) : int'(fb_mag);
                m = int'(mod_in) + fb;

                // Phase offset in 2^-32 turn units, wrapping modulo one turn.
                off = (64'(m < 0 ? -m : m) * 64'(live_index)) << 5;
                if (m < 0) begin
                    off = 64'd0 - off;
                end
                ph = phase_acc + off[31:0];

                // Quarter-wave sine evaluated by Horner steps.
                slot = ph[31 -: TABLE_BITS];
                quad = slot[TABLE_BITS-1 -: 2];
                r = 64'(slot[TABLE_BITS-3:0]) << (30 - (TABLE_BITS - 2));
                x = quad[0] ? (64'd1 << 30) - r : r;
                x2 = (x * x) >> 30;
                h = SIN_C9;
                h = SIN_C7 - ((x2 * h) >> 30);
                h = SIN_C5 - ((x2 * h) >> 30);
                h = SIN_C3 - ((x2 * h) >> 30);
                h = SIN_C1 - ((x2 * h) >> 30);
                y = ((x * h) >> 30) >> 15;
                if (y > 64'd32767) begin
                    y = 64'd32767;
                end
                s = quad[1] ? -int'(y) : int'(y);

                // Envelope, with the sustain level capped at full scale.
                sus = (sustain_lvl > 17'(ENV_FULL)) ? 32'(ENV_FULL) : 32'(sustain_lvl);
                env = 64'(env_value);
                case (env_stage)
                    ENV_ATTACK: begin
                        env = ENV_FULL - ((64'(attack_c) * (ENV_FULL - env)) >> 16);
                        if (env >= ENV_FULL) begin
                            env = ENV_FULL;
                            env_stage = ENV_DECAY;
                        end
                    end
                    ENV_DECAY: begin
                        if (env > 64'(sus)) begin
                            env = 64'(sus) + ((64'(decay_c) * (env - 64'(sus))) >> 16);
                        end
                        if (env <= 64'(sus) + DECAY_SNAP) begin
                            env = 64'(sus);
                            env_stage = ENV_SUSTAIN;
                        end
                    end
                    ENV_SUSTAIN: begin
                        env = 64'(sus);
                    end
                    ENV_RELEASE: begin
                        env = (64'(release_c) * env) >> 16;
                        if (env == 64'd0) begin
                            env_stage = ENV_IDLE;
                        end
                    end
                    default: begin
                        env = 64'd0;
                        env_stage = ENV_IDLE;
                    end
                endcase
                env_value = env[16:0];

                // Scale by envelope and output level, then saturate.
                scaled = (64'(s < 0 ? -s : s) * env) >> 16;
                scaled = (scaled * 64'(out_level)) >> 16;
                if (s < 0) begin
                    s = (scaled > 64'd32768) ? -32768 : -int'(scaled);
                end else begin
                    s = (scaled > 64'd32767) ? 32767 : int'(scaled);
                end

                phase_acc = phase_acc + step_size;
                prior_output = 16'(s);
                res.sample = 16'(s);
            end
            OP_NOTE_ON: begin
                step_size = fields[47:16];
                live_index = fields[63:48];
                prior_output = '0;
                env_stage = ENV_ATTACK;
            end
            OP_NOTE_OFF: begin
                if (env_stage != ENV_IDLE) begin
                    env_stage = ENV_RELEASE;
                end
            end
            default: begin
                phase_acc = '0;
                prior_output = '0;
                live_index = idx_sus;
                env_value = '0;
                env_stage = ENV_IDLE;
            end
        endcase
        res.active = (env_stage != ENV_IDLE);
        return res;
    endfunction

    initial begin
        o_failures = 0;
        o_outstanding = 0;
    end

    // Register writes, predictions and in-order comparison.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            attack_c     = '0;
            decay_c      = '0;
            release_c    = '0;
            sustain_lvl  = 17'd65536;
            idx_sus      = '0;
            idx_decay    = '0;
            fb_gain      = '0;
            out_level    = 17'd65536;
            phase_acc    = '0;
            step_size    = '0;
            live_index   = '0;
            prior_output = '0;
            env_value    = '0;
            env_stage    = ENV_IDLE;
            due_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[CFG_ADDR_W-1:2])
                    REG_ATTACK:    attack_c    = i_pwdata[15:0];
                    REG_DECAY:     decay_c     = i_pwdata[15:0];
                    REG_RELEASE:   release_c   = i_pwdata[15:0];
                    REG_SUSTAIN:   sustain_lvl = i_pwdata[16:0];
                    REG_IDX_SUS:   idx_sus     = i_pwdata[15:0];
                    REG_IDX_DECAY: idx_decay   = i_pwdata[15:0];
                    REG_FEEDBACK:  fb_gain     = i_pwdata[15:0];
                    REG_LEVEL:     out_level   = i_pwdata[16:0];
                    default: ;
                endcase
            end

            if (i_rsp_valid && i_rsp_ready) begin
                if (due_results.size() == 0) begin
                    $display("%t: result with nothing expected: sample %0d active %0b",
                             $realtime, $signed(i_rsp_data), i_rsp_user[0]);
                    o_failures++;
                end else begin
                    want = due_results.pop_front();
                    if (i_rsp_data !== want.sample) begin
                        $display("%t: sample mismatch, expected %0d, got %0d",
                                 $realtime, $signed(want.sample), $signed(i_rsp_data));
                        o_failures++;
                    end
                    if (i_rsp_user[0] !== want.active) begin
                        $display("%t: active mismatch, expected %0b, got %0b",
                                 $realtime, want.active, i_rsp_user[0]);
                        o_failures++;
                    end
                end
            end

            if (i_req_valid && i_req_ready) begin
                due_results.push_back(operator_step(i_req_user, i_req_data));
            end
        end
        o_outstanding = due_results.size();
    end

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus for the FM operator with its ADSR envelope. A short directed
// sequence covers field extremes, every opcode and the envelope corner
// cases, then random notes run under several register settings while both
// stream sides stall at random. The checker beside the block predicts and
// compares every result.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fmop_pkg::*;

    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 30;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_data = '0;    // mod_input, phase_step, start_index
    logic [1:0]  s_user = OP_SAMPLE;  // opcode
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_data;         // sample
    logic [0:0]  m_user;         // active
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int failures;
    int outstanding;

    bit hold_request = 1'b0;
    bit quiet_tail   = 1'b0;
    bit sender_gaps  = 1'b1;

    int n_sample, n_note_on, n_note_off, n_voice_reset, n_settings;

    fm_operator_with_envelope_unit u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    fmop_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req_valid   (s_valid),
        .i_req_ready   (s_ready),
        .i_req_data    (s_data),
        .i_req_user    (s_user),
        .i_rsp_valid   (m_valid),
        .i_rsp_ready   (m_ready),
        .i_rsp_data    (m_data),
        .i_rsp_user    (m_user),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_failures    (failures),
        .o_outstanding (outstanding)
    );

    // Clock.
    initial begin
        forever #4 clk = ~clk;
    end

    // Run limit.
    initial begin
        #4_000_000;
        $display("fm_operator_with_envelope_unit test failed");
        $finish;
    end

    // Result side: random stalls, one long hold-off on request, none at the tail.
    initial begin
        @(posedge clk);
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // One request; tvalid stays high afterwards so a following request
    // goes out back to back.
    task automatic send_request(input logic [1:0] op, input logic [63:0] fields);
        if (sender_gaps && !quiet_tail && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= fields;
        do @(posedge clk); while (!s_ready);
        case (op)
            OP_SAMPLE:   n_sample++;
            OP_NOTE_ON:  n_note_on++;
            OP_NOTE_OFF: n_note_off++;
            default:     n_voice_reset++;
        endcase
    endtask

    // Stop sending and wait until every predicted result has arrived.
    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Poles: mostly fast enough for the envelope to move within a note.
    function automatic logic [31:0] coeff_pick();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'd65535;
            default: return $urandom_range(0, 58000);
        endcase
    endfunction

    // Q1.16 levels, including values past full scale.
    function automatic logic [31:0] level_pick();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'd65536;
            2:       return 32'd131071;
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    function automatic logic [63:0] sample_fields();
        logic [63:0] f;
        f = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       f[15:0] = 16'h8000;
            1:       f[15:0] = 16'h7FFF;
            default: ;
        endcase
        return f;
    endfunction

    function automatic logic [63:0] note_fields();
        logic [63:0] f;
        f = {$urandom, $urandom};
        if ($urandom_range(0, 1) == 0) begin
            f[47:16] = $urandom_range(0, 32'h0400_0000);
        end
        return f;
    endfunction

    task automatic randomize_settings();
        write_reg(REG_ATTACK, coeff_pick());
        write_reg(REG_DECAY, coeff_pick());
        write_reg(REG_RELEASE, coeff_pick());
        write_reg(REG_SUSTAIN, level_pick());
        write_reg(REG_IDX_SUS, $urandom_range(0, 65535));
        write_reg(REG_IDX_DECAY, coeff_pick());
        write_reg(REG_FEEDBACK, $urandom_range(0, 65535));
        write_reg(REG_LEVEL, level_pick());
        n_settings++;
    endtask

    // Mostly whole notes with random content, some stray control and samples.
    task automatic run_random(input int n_items);
        int sent, len, k;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(0, 15))
                0: begin
                    send_request(OP_RESET, {$urandom, $urandom});
                    sent++;
                end
                1: begin
                    send_request(OP_NOTE_OFF, {$urandom, $urandom});
                    sent++;
                end
                2, 3: begin
                    send_request(OP_SAMPLE, sample_fields());
                    sent++;
                end
                4: begin
                    send_request(OP_NOTE_ON, note_fields());
                    sent++;
                end
                default: begin
                    send_request(OP_NOTE_ON, note_fields());
                    len = $urandom_range(2, 60);
                    for (k = 0; k < len; k++) begin
                        send_request(OP_SAMPLE, sample_fields());
                    end
                    send_request(OP_NOTE_OFF, {$urandom, $urandom});
                    sent += len + 2;
                    len = $urandom_range(0, 30);
                    for (k = 0; k < len; k++) begin
                        send_request(OP_SAMPLE, sample_fields());
                    end
                    sent += len;
                end
            endcase
        end
    endtask

    // Main sequence.
    initial begin
        int ph;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default registers: idle samples, extreme note, release, retrigger,
        // voice reset and a note off while idle.
        send_request(OP_SAMPLE,   {48'h0, 16'h8000});
        send_request(OP_SAMPLE,   {48'h0, 16'h7FFF});
        send_request(OP_NOTE_ON,  {16'hFFFF, 32'hFFFF_FFFF, 16'h0000});
        send_request(OP_SAMPLE,   {48'h0, 16'h8000});
        send_request(OP_SAMPLE,   {48'h0, 16'h7FFF});
        send_request(OP_SAMPLE,   {48'h0, 16'h0000});
        send_request(OP_NOTE_OFF, 64'h0);
        send_request(OP_SAMPLE,   {48'h0, 16'h1234});
        send_request(OP_NOTE_ON,  64'h0);
        send_request(OP_NOTE_ON,  {16'h1000, 32'h4000_0000, 16'h0000});
        send_request(OP_SAMPLE,   {48'h0, 16'h4000});
        send_request(OP_RESET,    64'h0);
        send_request(OP_NOTE_OFF, 64'h0);
        send_request(OP_SAMPLE,   64'h0);
        drain();

        // Instant envelope, oversized sustain and level, maximum index and
        // feedback, instant release.
        write_reg(REG_ATTACK, 32'd0);
        write_reg(REG_DECAY, 32'd0);
        write_reg(REG_RELEASE, 32'd0);
        write_reg(REG_SUSTAIN, 32'd131071);
        write_reg(REG_IDX_SUS, 32'd65535);
        write_reg(REG_IDX_DECAY, 32'd65535);
        write_reg(REG_FEEDBACK, 32'd65535);
        write_reg(REG_LEVEL, 32'd131071);
        n_settings++;
        send_request(OP_NOTE_ON,  {16'h0000, 32'h0123_4567, 16'h0000});
        send_request(OP_SAMPLE,   {48'h0, 16'h8000});
        send_request(OP_SAMPLE,   {48'h0, 16'h7FFF});
        send_request(OP_SAMPLE,   64'h0);
        send_request(OP_NOTE_OFF, 64'h0);
        send_request(OP_SAMPLE,   64'h0);
        drain();

        // Sustain raised above the envelope while it is still decaying.
        write_reg(REG_DECAY, 32'd60000);
        write_reg(REG_SUSTAIN, 32'd0);
        write_reg(REG_LEVEL, 32'd65536);
        write_reg(REG_FEEDBACK, 32'd30000);
        n_settings++;
        send_request(OP_NOTE_ON, {16'h0800, 32'h0100_0000, 16'h0000});
        send_request(OP_SAMPLE,  {48'h0, 16'h2000});
        send_request(OP_SAMPLE,  {48'h0, 16'hE000});
        send_request(OP_SAMPLE,  {48'h0, 16'h0100});
        drain();
        write_reg(REG_SUSTAIN, 32'd65000);
        n_settings++;
        send_request(OP_SAMPLE,  {48'h0, 16'h0100});

        // Random notes under fresh settings; one phase holds off the result
        // side for a long stretch, the last phase runs without stalls.
        for (ph = 0; ph < 9; ph++) begin
            drain();
            randomize_settings();
            sender_gaps = (ph != 3);
            if (ph == 3) begin
                hold_request = 1'b1;
            end
            if (ph == 8) begin
                quiet_tail = 1'b1;
            end
            run_random(ph == 8 ? 105 : 95);
        end
        drain();

        $display("Covered %0d samples, %0d note-on, %0d note-off and %0d voice resets",
                 n_sample, n_note_on, n_note_off, n_voice_reset);
        $display("across %0d register settings, with random stalls and one long hold-off.",
                 n_settings);
        if (failures == 0) begin
            $display("fm_operator_with_envelope_unit test passed");
        end else begin
            $display("fm_operator_with_envelope_unit test failed");
        end
        $finish;
    end

endmodule
